// File: rtl/bounded_vector_insert_erase_find_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded vector block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_VECTOR_INSERT_ERASE_FIND_ASSERT_SVH
`define BOUNDED_VECTOR_INSERT_ERASE_FIND_ASSERT_SVH

// Same-cycle implication.
`define BVIEF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BVIEF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bvief_pkg.sv
// ----------------------------------------------------------------------------
// bvief_pkg
// Shared types and operation codes of the bounded vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package bvief_pkg;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_DROP   = 3'd1,
    FN_INSERT = 3'd2,
    FN_ERASE  = 3'd3,
    FN_READ   = 3'd4,
    FN_FIND   = 3'd5,
    FN_CLEAR  = 3'd6
  } func_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         index;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] result_value;
    logic [2:0]         result_index;
    logic [3:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

  // Entry update broadcast to every cell.
  typedef struct packed {
    logic  en;
    func_e op;
  } upd_t;

  // Control part of the scan token that walks the cell row.
  typedef struct packed {
    logic       valid;
    logic       is_find;
    logic       hit;
    logic [3:0] idx;
    logic [2:0] pos;
  } tok_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bvief_cell.sv
// ----------------------------------------------------------------------------
// bvief_cell
// One list slot: holds an entry, shifts with its neighbors, checks the scan
// token as it passes.
// ----------------------------------------------------------------------------
`default_nettype none

module bvief_cell #(
  parameter int DW  = 32,
  parameter int XW  = 4,
  parameter int POS = 0
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire bvief_pkg::upd_t    upd_i,
  input  wire  [DW-1:0]           word_i,
  input  wire  [XW-1:0]           idx_i,
  input  wire  [XW-1:0]           cnt_i,
  input  wire  [DW-1:0]           lower_i,
  input  wire  [DW-1:0]           upper_i,
  output logic [DW-1:0]           entry_o,
  input  wire bvief_pkg::tok_ctl_t tok_ctl_i,
  input  wire  [DW-1:0]           tok_key_i,
  input  wire  [DW-1:0]           tok_val_i,
  output bvief_pkg::tok_ctl_t     tok_ctl_o,
  output logic [DW-1:0]           tok_key_o,
  output logic [DW-1:0]           tok_val_o
);

  localparam logic [XW-1:0] POS_X   = XW'(POS);
  localparam logic [2:0]    POS_LOW = 3'(POS);

  logic [DW-1:0]       entry_q, entry_d;
  bvief_pkg::tok_ctl_t tok_ctl_q, tok_ctl_d;
  logic [DW-1:0]       tok_key_q, tok_val_q, tok_val_d;
  logic                match, take;

  // Shift with the neighbors on insert and erase, load on append.
  always_comb begin
    entry_d = entry_q;
    if (upd_i.en) begin
      case (upd_i.op)
        bvief_pkg::FN_APPEND: begin
          if (cnt_i == POS_X) entry_d = word_i;
        end
        bvief_pkg::FN_INSERT: begin
          if (idx_i == POS_X) begin
            entry_d = word_i;
          end else if (POS_X > idx_i && POS_X <= cnt_i) begin
            entry_d = lower_i;
          end
        end
        bvief_pkg::FN_ERASE: begin
          if (POS_X >= idx_i) entry_d = upper_i;
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  // First live slot that matches takes the token.
  always_comb begin
    match     = tok_ctl_i.is_find ? (entry_q == tok_key_i)
                                  : (XW'(tok_ctl_i.idx) == POS_X);
    take      = tok_ctl_i.valid && !tok_ctl_i.hit && (POS_X < cnt_i) && match;
    tok_ctl_d = tok_ctl_i;
    tok_val_d = tok_val_i;
    if (take) begin
      tok_ctl_d.hit = 1'b1;
      tok_ctl_d.pos = tok_ctl_i.is_find ? POS_LOW : 3'd0;
      tok_val_d     = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q   <= entry_d;
    tok_key_q <= tok_key_i;
    tok_val_q <= tok_val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_ctl_q <= '0;
    end else begin
      tok_ctl_q <= tok_ctl_d;
    end
  end

  assign entry_o   = entry_q;
  assign tok_ctl_o = tok_ctl_q;
  assign tok_key_o = tok_key_q;
  assign tok_val_o = tok_val_q;

endmodule

`default_nettype wire

// File: rtl/bvief_out.sv
// ----------------------------------------------------------------------------
// bvief_out
// Result register with one skid slot behind it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_vector_insert_erase_find_assert.svh"

module bvief_out (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire bvief_pkg::rsp_t push_rsp_i,
  output logic                 skid_free_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output bvief_pkg::rsp_t      out_rsp_o
);

  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  bvief_pkg::rsp_t out_rsp_q, out_rsp_d;
  bvief_pkg::rsp_t skid_rsp_q, skid_rsp_d;
  logic            pop;

  always_comb begin
    pop          = out_valid_q && out_ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_rsp_d    = out_rsp_q;
    skid_rsp_d   = skid_rsp_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_rsp_d    = skid_rsp_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_rsp_d = push_rsp_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_rsp_d   = push_rsp_i;
        skid_valid_d = 1'b1;
      end else begin
        out_rsp_d   = push_rsp_i;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q  <= out_rsp_d;
    skid_rsp_q <= skid_rsp_d;
  end

  assign skid_free_o = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `BVIEF_ASSERT_IMP(a_push_skid_free, push_i, !skid_valid_q, "result pushed into full skid")
  `BVIEF_ASSERT_IMP(a_skid_behind_head, skid_valid_q, out_valid_q, "skid holds without head")
  `BVIEF_ASSERT_NXT(a_drain_empty, pop && !push_i && !skid_valid_q, !out_valid_q,
    "head stays valid after last pop")

endmodule

`default_nettype wire

// File: rtl/bounded_vector_insert_erase_find.sv
// ----------------------------------------------------------------------------
// bounded_vector_insert_erase_find
// Fixed-capacity ordered list of signed words built as a row of cells.
// ----------------------------------------------------------------------------
// Each request performs one operation on a list of up to CAPACITY entries:
// append, drop last, insert or erase at an index (later entries move), read
// at an index, find the first equal entry, or clear. On append, drop,
// insert, erase, clear and the unused code the cells shift in parallel
// and the result is registered. Read and find send a token down the row
// of CAPACITY cells, one cell per cycle, and no new request is taken
// until the token leaves the last cell and its result is registered.
// One finished result may wait in a skid slot behind the output register,
// so a request is still taken while the output is stalled, as long as
// that slot is empty. Entries start undefined and need no clearing pass;
// of the list state, only the count is reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_vector_insert_erase_find_assert.svh"

module bounded_vector_insert_erase_find #(
  parameter int CAPACITY   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire bvief_pkg::req_t in_req_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output bvief_pkg::rsp_t      out_rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 4) ? CW : 4;
  localparam int DW = DATA_WIDTH;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  logic [CW-1:0]       count_q, count_d, count_nxt;
  logic                scan_busy_q, scan_busy_d;
  bvief_pkg::func_e    fn;
  logic [DW-1:0]       word;
  logic [XW-1:0]       idx_x, cnt_x;
  logic                in_acc, ok_imm, is_scan, scan_done;
  logic                push, skid_free;
  bvief_pkg::rsp_t     push_rsp;
  bvief_pkg::upd_t     upd;
  bvief_pkg::tok_ctl_t tok_inj;

  logic [DW-1:0]       entry   [CAPACITY];
  bvief_pkg::tok_ctl_t tok_ctl [CAPACITY];
  logic [DW-1:0]       tok_key [CAPACITY];
  logic [DW-1:0]       tok_val [CAPACITY];

  // Decode the request and check bounds against the current count.
  always_comb begin
    fn        = bvief_pkg::func_e'(in_req_i.func);
    word      = DW'(in_req_i.value);
    idx_x     = XW'(in_req_i.index);
    cnt_x     = XW'(count_q);
    ok_imm    = 1'b0;
    is_scan   = 1'b0;
    count_nxt = count_q;
    unique case (fn)
      bvief_pkg::FN_APPEND: begin
        ok_imm    = cnt_x < CAP_X;
        count_nxt = CW'(count_q + 1'b1);
      end
      bvief_pkg::FN_DROP: begin
        ok_imm    = count_q != '0;
        count_nxt = CW'(count_q - 1'b1);
      end
      bvief_pkg::FN_INSERT: begin
        ok_imm    = (cnt_x < CAP_X) && (idx_x <= cnt_x);
        count_nxt = CW'(count_q + 1'b1);
      end
      bvief_pkg::FN_ERASE: begin
        ok_imm    = idx_x < cnt_x;
        count_nxt = CW'(count_q - 1'b1);
      end
      bvief_pkg::FN_READ,
      bvief_pkg::FN_FIND: begin
        is_scan = 1'b1;
      end
      bvief_pkg::FN_CLEAR: begin
        ok_imm    = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok_imm = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !scan_busy_q && skid_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Broadcast the entry update to the row; refused requests leave it alone.
  assign upd.en = in_acc && ok_imm;
  assign upd.op = fn;

  // Launch a scan token into the first cell.
  always_comb begin
    tok_inj         = '0;
    tok_inj.valid   = in_acc && is_scan;
    tok_inj.is_find = fn == bvief_pkg::FN_FIND;
    tok_inj.idx     = in_req_i.index;
  end

  assign scan_done = tok_ctl[CAPACITY-1].valid;

  always_comb begin
    count_d     = (in_acc && ok_imm) ? count_nxt : count_q;
    scan_busy_d = scan_busy_q;
    if (in_acc && is_scan) begin
      scan_busy_d = 1'b1;
    end else if (scan_done) begin
      scan_busy_d = 1'b0;
    end
  end

  // Build the result: either from this cycle's request or from the token
  // leaving the last cell. The two never coincide since a scan holds off
  // new requests.
  always_comb begin
    push     = (in_acc && !is_scan) || scan_done;
    push_rsp = '0;
    if (scan_done) begin
      push_rsp.ok = tok_ctl[CAPACITY-1].hit;
      if (tok_ctl[CAPACITY-1].hit) begin
        push_rsp.result_value = 32'($signed(tok_val[CAPACITY-1]));
        push_rsp.result_index = tok_ctl[CAPACITY-1].pos;
      end
    end else begin
      push_rsp.ok = ok_imm;
    end
    push_rsp.entry_count = 4'(count_d);
    push_rsp.is_empty    = count_d == '0;
    push_rsp.is_full     = count_d == CAP_C;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_busy_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_busy_q <= scan_busy_d;
    end
  end

  // Row of cells; each sees its neighbors' entries and passes the token on.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DW-1:0]       lower, upper;
    bvief_pkg::tok_ctl_t ctl_in;
    logic [DW-1:0]       key_in, val_in;

    if (k == 0) begin : g_head
      assign lower  = entry[k];
      assign ctl_in = tok_inj;
      assign key_in = word;
      assign val_in = '0;
    end else begin : g_body
      assign lower  = entry[k-1];
      assign ctl_in = tok_ctl[k-1];
      assign key_in = tok_key[k-1];
      assign val_in = tok_val[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign upper = entry[k];
    end else begin : g_inner
      assign upper = entry[k+1];
    end

    bvief_cell #(
      .DW  (DW),
      .XW  (XW),
      .POS (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .upd_i     (upd),
      .word_i    (word),
      .idx_i     (idx_x),
      .cnt_i     (cnt_x),
      .lower_i   (lower),
      .upper_i   (upper),
      .entry_o   (entry[k]),
      .tok_ctl_i (ctl_in),
      .tok_key_i (key_in),
      .tok_val_i (val_in),
      .tok_ctl_o (tok_ctl[k]),
      .tok_key_o (tok_key[k]),
      .tok_val_o (tok_val[k])
    );
  end

  bvief_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_rsp_i  (push_rsp),
    .skid_free_o (skid_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  `BVIEF_ASSERT_NXT(a_scan_holds_off, in_acc && is_scan, scan_busy_q, "scan did not block requests")
  `BVIEF_ASSERT_IMP(a_token_while_busy, scan_done, scan_busy_q, "token left row while idle")
  `BVIEF_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CAP_C, "count above capacity")

endmodule

`default_nettype wire
